// File: rtl/ksfh_pkg.sv
// Shared types, constants and SHA-256 helper functions for the keyed feature hash.
package ksfh_pkg;

    localparam int DEFAULT_MAX_HASHES = 1024;
    localparam int KEY_W = 64;
    localparam int HPD_W = 11;
    localparam int WORD_W = 32;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_HASH_KEY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASHES_PER_DOC = 8'd1;

    localparam logic [WORD_W-1:0] TAG_WORD_A = 32'h5045445f;
    localparam logic [WORD_W-1:0] TAG_WORD_B = 32'h50524931;
    localparam logic [WORD_W-1:0] PAD_MARKER = 32'h80000000;
    localparam logic [WORD_W-1:0] MSG_BIT_LEN = 32'd192;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [15:0][WORD_W-1:0] block_t;
    typedef logic [7:0][WORD_W-1:0] hash_t;

    // Control from the sequencer to the schedule and round units.
    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] rnd;
    } core_ctrl_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t start_h(input logic [2:0] idx);
        case (idx)
            3'd0: start_h = 32'h6a09e667;
            3'd1: start_h = 32'hbb67ae85;
            3'd2: start_h = 32'h3c6ef372;
            3'd3: start_h = 32'ha54ff53a;
            3'd4: start_h = 32'h510e527f;
            3'd5: start_h = 32'h9b05688c;
            3'd6: start_h = 32'h1f83d9ab;
            default: start_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// File: rtl/ksfh_msg_sched.sv
// SHA-256 message schedule: a sliding 16-word window that yields one word per round.
module ksfh_msg_sched (
    input  logic                aclk,
    input  ksfh_pkg::core_ctrl_t ctrl,
    input  ksfh_pkg::block_t    block,
    output ksfh_pkg::word_t     w_t
);

    ksfh_pkg::block_t win_reg;
    ksfh_pkg::block_t win_next;
    ksfh_pkg::word_t  w_new;

    // Word t+16 of the schedule, from the window that starts at word t.
    always_comb begin
        w_new = win_reg[0] + ksfh_pkg::small_sigma0(win_reg[1]) + win_reg[9]
              + ksfh_pkg::small_sigma1(win_reg[14]);
        win_next = win_reg;
        if (ctrl.load) begin
            win_next = block;
        end else if (ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = w_new;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign w_t = win_reg[0];

endmodule

// File: rtl/ksfh_round.sv
// SHA-256 round unit: working variables a to h, one round per step, final add to the digest.
module ksfh_round (
    input  logic                 aclk,
    input  ksfh_pkg::core_ctrl_t ctrl,
    input  ksfh_pkg::word_t      w_t,
    output ksfh_pkg::hash_t      digest
);

    ksfh_pkg::hash_t v_reg;
    ksfh_pkg::hash_t v_next;
    ksfh_pkg::word_t t1;
    ksfh_pkg::word_t t2;
    ksfh_pkg::word_t ch;
    ksfh_pkg::word_t maj;

    always_comb begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + ksfh_pkg::big_sigma1(v_reg[4]) + ch
            + ksfh_pkg::round_k(ctrl.rnd) + w_t;
        t2  = ksfh_pkg::big_sigma0(v_reg[0]) + maj;
        v_next = v_reg;
        if (ctrl.load) begin
            for (int i = 0; i < 8; i++) begin
                v_next[i] = ksfh_pkg::start_h(3'(i));
            end
        end else if (ctrl.step) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            digest[i] = ksfh_pkg::start_h(3'(i)) + v_reg[i];
        end
    end

endmodule

// File: rtl/keyed_sha256_feature_hash.sv
// Top level of the keyed SHA-256 feature hash: config, position counter, sequencer, output.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = signature, s_tuser = first_of_set
//  m_        out  m_tvalid/m_tready  m_tdata = digest_word0 .. digest_word7
//  cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// Each beat loads the message block, runs every SHA-256 round on the single
// shared round unit (one SHA-256 round per cycle), and then does the final add
// into the output register. Reset (aresetn low, synchronous)
// clears the key to zero, sets hashes_per_doc to one and the position to zero.
// s_tready is high only while the sequencer is idle. A finished digest waits in
// the output register; the next beat may be accepted and hashed meanwhile, and
// only its final add waits until m_tready has taken the older result.
module keyed_sha256_feature_hash #(
    parameter int MAX_HASHES = ksfh_pkg::DEFAULT_MAX_HASHES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input beat.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // [31:0] signature
    input  logic                                s_tuser,   // [0] first_of_set
    // Result beat.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [255:0]                        m_tdata,   // [32k+31:32k] digest_word k, k=0..7
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [ksfh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ksfh_pkg::KEY_W-1:0]          cfg_wdata
);

    // Position fits below MAX_HASHES; the modulus must hold MAX_HASHES and
    // every value of the 11-bit register.
    localparam int PW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int MW0 = $clog2(MAX_HASHES + 1);
    localparam int MW = (MW0 > ksfh_pkg::HPD_W) ? MW0 : ksfh_pkg::HPD_W;
    localparam logic [MW-1:0] MAX_MOD = MW'(MAX_HASHES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [5:0]                    rnd_reg, rnd_next;
    logic [ksfh_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [ksfh_pkg::HPD_W-1:0]    hpd_reg, hpd_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic                          out_valid_reg, out_valid_next;
    logic [255:0]                  out_data_reg, out_data_next;

    logic                          accept;
    logic                          finish;
    logic [MW-1:0]                 modulus;
    logic [MW-1:0]                 item_pos;
    logic [MW-1:0]                 pos_inc;
    ksfh_pkg::block_t              block;
    ksfh_pkg::core_ctrl_t          ctrl;
    ksfh_pkg::word_t               w_t;
    ksfh_pkg::hash_t               digest;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The final add may land once the output register is free or being emptied.
    assign finish   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Effective modulus: zero acts as one, anything above MAX_HASHES is clamped.
    always_comb begin
        modulus = MW'(hpd_reg);
        if (hpd_reg == '0) begin
            modulus = MW'(1);
        end else if (modulus > MAX_MOD) begin
            modulus = MAX_MOD;
        end
        item_pos = s_tuser ? '0 : MW'(pos_reg);
        // A position left over from a larger modulus restarts at zero.
        if (item_pos >= modulus) begin
            item_pos = '0;
        end
        pos_inc = item_pos + MW'(1);
    end

    // The padded 24-byte message as one 512-bit block, word 0 first.
    always_comb begin
        block     = '0;
        block[0]  = ksfh_pkg::TAG_WORD_A;
        block[1]  = ksfh_pkg::TAG_WORD_B;
        block[2]  = key_reg[63:32];
        block[3]  = key_reg[31:0];
        block[4]  = {{(32-PW){1'b0}}, item_pos[PW-1:0]};
        block[5]  = s_tdata;
        block[6]  = ksfh_pkg::PAD_MARKER;
        block[15] = ksfh_pkg::MSG_BIT_LEN;
    end

    always_comb begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        key_next       = key_reg;
        hpd_next       = hpd_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ctrl.load      = 1'b0;
        ctrl.step      = 1'b0;
        ctrl.rnd       = rnd_reg;

        if (cfg_we) begin
            if (cfg_index == ksfh_pkg::REG_HASH_KEY) begin
                key_next = cfg_wdata;
            end else if (cfg_index == ksfh_pkg::REG_HASHES_PER_DOC) begin
                hpd_next = cfg_wdata[ksfh_pkg::HPD_W-1:0];
            end
        end

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                    pos_next   = (pos_inc >= modulus) ? '0 : pos_inc[PW-1:0];
                end
            end
            ST_ROUND: begin
                ctrl.step = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    out_valid_next = 1'b1;
                    out_data_next  = digest;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            key_reg       <= '0;
            hpd_reg       <= ksfh_pkg::HPD_W'(1);
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            key_reg       <= key_next;
            hpd_reg       <= hpd_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    ksfh_msg_sched u_sched (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .block (block),
        .w_t   (w_t)
    );

    ksfh_round u_round (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .w_t    (w_t),
        .digest (digest)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
